@@ src/battery_monitor_frame_decoder_top_defines.svh @@
`ifndef BATTERY_MONITOR_FRAME_DECODER_TOP_DEFINES_SVH
`define BATTERY_MONITOR_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define BMFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BMFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bmfd_pkg.sv @@
package bmfd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [10:0] ID_BATT = 11'h100;
  localparam logic [10:0] ID_CAP  = 11'h101;
  localparam logic [10:0] ID_STAT = 11'h103;

  localparam logic [3:0] FULL_LEN = 4'd8;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_CRC_ERR   = 3'd1,
    ST_SHORT     = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_PUBLISHED = 3'd4,
    ST_NOT_READY = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FID_BATT,
    FID_CAP,
    FID_STAT,
    FID_OTHER
  } fid_t;

  // classified frame, CRC run over bytes 0..2 already
  typedef struct packed {
    logic        is_pub;
    logic        is_short;
    fid_t        fid;
    logic [15:0] crc_part;
    logic [47:0] data;
    logic [15:0] check;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

@@ src/bmfd_in_if.sv @@
interface bmfd_in_if;
  import bmfd_pkg::*;

  logic        valid;
  logic        ready;
  logic        command;
  logic [10:0] frame_id;
  logic [3:0]  data_length;
  logic [63:0] payload;

  modport source (output valid, command, frame_id, data_length, payload, input ready);
  modport sink (input valid, command, frame_id, data_length, payload, output ready);
endinterface

@@ src/bmfd_out_if.sv @@
interface bmfd_out_if;
  import bmfd_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [15:0]        pack_voltage;
  logic signed [15:0] pack_current;
  logic [15:0]        remaining_charge;
  logic [15:0]        full_charge;
  logic [15:0]        state_of_charge;
  logic [15:0]        cycle_total;
  logic               charge_switch_on;
  logic               discharge_switch_on;
  logic [15:0]        firmware_version;
  logic               is_charging;

  modport source (
    output valid, status, pack_voltage, pack_current, remaining_charge, full_charge,
           state_of_charge, cycle_total, charge_switch_on, discharge_switch_on,
           firmware_version, is_charging,
    input  ready
  );
  modport sink (
    input  valid, status, pack_voltage, pack_current, remaining_charge, full_charge,
           state_of_charge, cycle_total, charge_switch_on, discharge_switch_on,
           firmware_version, is_charging,
    output ready
  );
endinterface

@@ src/bmfd_front.sv @@
module bmfd_front import bmfd_pkg::*; (
  bmfd_in_if.sink in_ch,
  input  qstat_t  q_stat,
  output logic    push,
  output qent_t   push_ent
);

  logic [15:0] crc0;
  logic [15:0] crc1;
  logic [15:0] crc2;
  fid_t        fid;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    crc0 = crc_byte(CRC_INIT, in_ch.payload[63:56]);
    crc1 = crc_byte(crc0, in_ch.payload[55:48]);
    crc2 = crc_byte(crc1, in_ch.payload[47:40]);
  end

  always_comb begin
    case (in_ch.frame_id)
      ID_BATT: fid = FID_BATT;
      ID_CAP:  fid = FID_CAP;
      ID_STAT: fid = FID_STAT;
      default: fid = FID_OTHER;
    endcase
  end

  always_comb begin
    push_ent.is_pub   = in_ch.command;
    push_ent.is_short = in_ch.data_length < FULL_LEN;
    push_ent.fid      = fid;
    push_ent.crc_part = crc2;
    push_ent.data     = in_ch.payload[63:16];
    push_ent.check    = in_ch.payload[15:0];
  end

endmodule

@@ src/bmfd_queue.sv @@
module bmfd_queue import bmfd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qent_t  push_ent,
  input  logic   pop,
  output qent_t  head,
  output qstat_t q_stat
);

  qent_t            ent_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QCntW-1:0] count_r;

  assign head         = ent_r[rd_ptr_r];
  assign q_stat.full  = count_r == QCntW'(QDepth);
  assign q_stat.empty = count_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ src/bmfd_back.sv @@
module bmfd_back import bmfd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  qent_t  head,
  input  qstat_t q_stat,
  output logic   pop,
  bmfd_out_if.source out_ch
);

  logic [15:0] volt_r, volt_nxt;
  logic [15:0] curr_r, curr_nxt;
  logic [15:0] chg_r, chg_nxt;
  logic [15:0] full_r, full_nxt;
  logic [15:0] soc_r, soc_nxt;
  logic [15:0] cyc_r, cyc_nxt;
  logic [1:0]  sw_r, sw_nxt;
  logic [15:0] ver_r, ver_nxt;
  logic [2:0]  seen_r, seen_nxt;

  logic        out_valid_r;
  logic        load;
  logic [15:0] crc3, crc4, crc5;
  logic        crc_ok;

  status_t            res_status_r, res_status_nxt;
  logic [15:0]        res_volt_r, res_volt_nxt;
  logic signed [15:0] res_curr_r, res_curr_nxt;
  logic [15:0]        res_chg_r, res_chg_nxt;
  logic [15:0]        res_full_r, res_full_nxt;
  logic [15:0]        res_soc_r, res_soc_nxt;
  logic [15:0]        res_cyc_r, res_cyc_nxt;
  logic [1:0]         res_sw_r, res_sw_nxt;
  logic [15:0]        res_ver_r, res_ver_nxt;
  logic               res_chgng_r, res_chgng_nxt;

  assign load = !out_valid_r || out_ch.ready;
  assign pop  = !q_stat.empty && load;

  always_comb begin
    crc3   = crc_byte(head.crc_part, head.data[23:16]);
    crc4   = crc_byte(crc3, head.data[15:8]);
    crc5   = crc_byte(crc4, head.data[7:0]);
    crc_ok = crc5 == head.check;
  end

  always_comb begin
    volt_nxt = volt_r;
    curr_nxt = curr_r;
    chg_nxt  = chg_r;
    full_nxt = full_r;
    soc_nxt  = soc_r;
    cyc_nxt  = cyc_r;
    sw_nxt   = sw_r;
    ver_nxt  = ver_r;
    seen_nxt = seen_r;

    res_status_nxt = ST_STORED;
    res_volt_nxt   = '0;
    res_curr_nxt   = '0;
    res_chg_nxt    = '0;
    res_full_nxt   = '0;
    res_soc_nxt    = '0;
    res_cyc_nxt    = '0;
    res_sw_nxt     = '0;
    res_ver_nxt    = '0;
    res_chgng_nxt  = 1'b0;

    if (head.is_pub) begin
      if (seen_r[1:0] != 2'b11) begin
        res_status_nxt = ST_NOT_READY;
      end else begin
        res_status_nxt = ST_PUBLISHED;
        res_volt_nxt   = volt_r;
        res_curr_nxt   = curr_r;
        res_chg_nxt    = chg_r;
        res_full_nxt   = full_r;
        res_soc_nxt    = soc_r;
        res_cyc_nxt    = cyc_r;
        res_sw_nxt     = sw_r;
        res_ver_nxt    = ver_r;
        res_chgng_nxt  = !curr_r[15];
        seen_nxt       = '0;
      end
    end else if (head.is_short) begin
      res_status_nxt = ST_SHORT;
    end else if (!crc_ok) begin
      res_status_nxt = ST_CRC_ERR;
    end else begin
      case (head.fid)
        FID_BATT: begin
          volt_nxt    = head.data[47:32];
          curr_nxt    = head.data[31:16];
          chg_nxt     = head.data[15:0];
          seen_nxt[0] = 1'b1;
        end
        FID_CAP: begin
          full_nxt    = head.data[47:32];
          cyc_nxt     = head.data[31:16];
          soc_nxt     = head.data[15:0];
          seen_nxt[1] = 1'b1;
        end
        FID_STAT: begin
          sw_nxt      = head.data[33:32];
          ver_nxt     = head.data[15:0];
          seen_nxt[2] = 1'b1;
        end
        default: begin
          res_status_nxt = ST_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_r      <= '0;
      curr_r      <= '0;
      chg_r       <= '0;
      full_r      <= '0;
      soc_r       <= '0;
      cyc_r       <= '0;
      sw_r        <= '0;
      ver_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= pop;
      end
      if (pop) begin
        volt_r <= volt_nxt;
        curr_r <= curr_nxt;
        chg_r  <= chg_nxt;
        full_r <= full_nxt;
        soc_r  <= soc_nxt;
        cyc_r  <= cyc_nxt;
        sw_r   <= sw_nxt;
        ver_r  <= ver_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_status_r <= res_status_nxt;
      res_volt_r   <= res_volt_nxt;
      res_curr_r   <= res_curr_nxt;
      res_chg_r    <= res_chg_nxt;
      res_full_r   <= res_full_nxt;
      res_soc_r    <= res_soc_nxt;
      res_cyc_r    <= res_cyc_nxt;
      res_sw_r     <= res_sw_nxt;
      res_ver_r    <= res_ver_nxt;
      res_chgng_r  <= res_chgng_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.status              = res_status_r;
  assign out_ch.pack_voltage        = res_volt_r;
  assign out_ch.pack_current        = res_curr_r;
  assign out_ch.remaining_charge    = res_chg_r;
  assign out_ch.full_charge         = res_full_r;
  assign out_ch.state_of_charge     = res_soc_r;
  assign out_ch.cycle_total         = res_cyc_r;
  assign out_ch.charge_switch_on    = res_sw_r[0];
  assign out_ch.discharge_switch_on = res_sw_r[1];
  assign out_ch.firmware_version    = res_ver_r;
  assign out_ch.is_charging         = res_chgng_r;

endmodule

@@ src/battery_monitor_frame_decoder_top.sv @@
// channel | dir | handshake          | payload
// in_ch   | in  | valid/ready        | command, frame_id, data_length, payload
// out_ch  | out | valid/ready        | status and stored snapshot fields
//
// One transaction per cycle sustained while out_ch.ready stays high; a frame's result
// passes through the queue entry and then the output register, loaded when the output
// side is free (front CRC bytes 0-2, queue, back CRC bytes 3-5 and state update).
// Reset is synchronous, active low, and clears the stored fields and seen flags.
// A stalled output holds its transaction; the two-entry queue lowers in_ch.ready
// only once full.
`include "battery_monitor_frame_decoder_top_defines.svh"

module battery_monitor_frame_decoder_top import bmfd_pkg::*; (
  input logic clk,
  input logic rst_n,
  bmfd_in_if.sink    in_ch,
  bmfd_out_if.source out_ch
);

  logic   push;
  logic   pop;
  qent_t  push_ent;
  qent_t  head;
  qstat_t q_stat;

  bmfd_front u_front (
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_ent (push_ent)
  );

  bmfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  bmfd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  `BMFD_ASSERT_NOW(a_unpub_zero, out_ch.valid && out_ch.status != ST_PUBLISHED, out_ch.pack_voltage == '0 && out_ch.pack_current == '0 && out_ch.firmware_version == '0 && !out_ch.is_charging, "non-publish result carries data")
  `BMFD_ASSERT_NOW(a_charging_sign, out_ch.valid && out_ch.status == ST_PUBLISHED, out_ch.is_charging == !out_ch.pack_current[15], "is_charging disagrees with current sign")
  `BMFD_ASSERT_NEXT(a_queue_hold, push && !pop, !q_stat.empty, "queue lost a pushed transaction")

endmodule
